// ===== rtl/haversine_distance_defines.svh =====
// ----------------------------------------------------------------------------
// haversine distance assertion macros
// shared property forms for the block's concurrent checks
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_DEFINES_SVH
`define HAVERSINE_DISTANCE_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define HAV_ASSERT_NOW(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define HAV_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/hav_pkg.sv =====
// ----------------------------------------------------------------------------
// hav_pkg
// shared types, constants and arithmetic helpers of the haversine datapath
// ----------------------------------------------------------------------------
package hav_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_N     = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;

  localparam int LAT_W    = 28;
  localparam int LON_W    = 29;
  localparam int RADIUS_W = 24;
  localparam int DIST_W   = 36;

  typedef logic signed [33:0] cw_t;   // cordic x/y word
  typedef logic signed [32:0] ang_t;  // q2.30 angle with headroom
  typedef logic signed [31:0] q30_t;  // q2.30 value
  typedef logic        [30:0] uq30_t; // unsigned q1.30 value in [0, 2)

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 24'd6371000;

  localparam logic [35:0] HALF_UDEG_TO_RAD = 36'd40244552545;
  localparam logic [17:0] RAD_K_LO = HALF_UDEG_TO_RAD[17:0];
  localparam logic [17:0] RAD_K_HI = HALF_UDEG_TO_RAD[35:18];

  localparam cw_t   CORDIC_GAIN = 34'sd652032874;
  localparam ang_t  HALF_PI_ANG = 33'sd1686629713;
  localparam uq30_t HALF_PI_U   = 31'd1686629713;
  localparam uq30_t Q30_ONE     = 31'd1073741824;

  localparam int HALF_TURN_720 = 720000000;
  localparam int HALF_TURN_360 = 360000000;
  localparam int HALF_TURN_180 = 180000000;

  typedef struct packed {
    q30_t s1;
    q30_t s2;
    q30_t c1;
    q30_t c2;
    logic n1;
    logic n2;
  } sc_t;

  // q2.30 product, rounded half up with a flooring shift
  function automatic q30_t mulq(input q30_t a, input q30_t b);
    logic signed [63:0] p;
    p = a * b;
    p = p + 64'sd536870912;
    return q30_t'(p >>> 30);
  endfunction

  // q2.30 atan(2^-i)
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    case (i)
      5'd0:    return 32'd843314856;
      5'd1:    return 32'd497837829;
      5'd2:    return 32'd263043836;
      5'd3:    return 32'd133525158;
      5'd4:    return 32'd67021686;
      5'd5:    return 32'd33543515;
      5'd6:    return 32'd16775850;
      5'd7:    return 32'd8388437;
      5'd8:    return 32'd4194282;
      5'd9:    return 32'd2097149;
      5'd10:   return 32'd1048575;
      5'd11:   return 32'd524287;
      5'd12:   return 32'd262143;
      5'd13:   return 32'd131071;
      5'd14:   return 32'd65535;
      5'd15:   return 32'd32767;
      5'd16:   return 32'd16383;
      5'd17:   return 32'd8191;
      5'd18:   return 32'd4095;
      5'd19:   return 32'd2047;
      5'd20:   return 32'd1024;
      5'd21:   return 32'd511;
      5'd22:   return 32'd255;
      5'd23:   return 32'd127;
      5'd24:   return 32'd63;
      5'd25:   return 32'd31;
      5'd26:   return 32'd15;
      5'd27:   return 32'd8;
      5'd28:   return 32'd4;
      5'd29:   return 32'd2;
      5'd30:   return 32'd1;
      default: return 32'd0;
    endcase
  endfunction

endpackage

// ===== rtl/hav_if.sv =====
// ----------------------------------------------------------------------------
// haversine channel interfaces
// point pair input, distance output and radius write channel
// ----------------------------------------------------------------------------
interface hav_pts_if;
  logic                                valid;
  logic                                ready;
  logic signed [hav_pkg::LAT_W-1:0]    lat_a;
  logic signed [hav_pkg::LON_W-1:0]    lon_a;
  logic signed [hav_pkg::LAT_W-1:0]    lat_b;
  logic signed [hav_pkg::LON_W-1:0]    lon_b;
  modport source (output valid, lat_a, lon_a, lat_b, lon_b, input ready);
  modport sink   (input valid, lat_a, lon_a, lat_b, lon_b, output ready);
endinterface

interface hav_dist_if;
  logic                          valid;
  logic                          ready;
  logic [hav_pkg::DIST_W-1:0]    distance_mm;
  modport source (output valid, distance_mm, input ready);
  modport sink   (input valid, distance_mm, output ready);
endinterface

interface hav_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hav_pkg::RADIUS_W-1:0]  data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/haversine_distance.sv =====
// ----------------------------------------------------------------------------
// haversine_distance
// great-circle distance between two points in fixed point
// ----------------------------------------------------------------------------
// pts carries one point pair per transaction (lat/lon in signed microdegrees),
// result returns one distance_mm per pair, in order. cfg writes the sphere
// radius in metres and is always ready; write it only while no pair is in
// flight. reset sets the radius to 6371000 and empties the pipeline.
// the datapath is a fully pipelined chain: angle reduction and radian scale
// (5 stages), rotation cordic (CORDIC_N stages), products and clamp (4),
// bit-serial square roots (32), vectoring cordic (CORDIC_N) and radius
// scale (2). one pair is taken every cycle unless the receiver stalls;
// the cordic and root chains hold one item per stage.
// when the receiver stalls, stages fill up one by one and pts keeps taking
// pairs until every stage holds a valid item; pts.ready then drops.
// ----------------------------------------------------------------------------
`include "haversine_distance_defines.svh"

module haversine_distance (
  input  logic        clk,
  input  logic        rst,
  hav_pts_if.sink     pts,
  hav_dist_if.source  result,
  hav_cfg_if.sink     cfg
);

  logic [hav_pkg::RADIUS_W-1:0] sphere_radius_m;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_radius_m <= hav_pkg::RADIUS_RESET;
    end else if (cfg.valid) begin
      sphere_radius_m <= cfg.data;
    end
  end

  logic           sc_valid, sc_ready;
  hav_pkg::sc_t   sc;
  logic           pr_valid, pr_ready;
  hav_pkg::uq30_t aux;
  logic           sq_valid, sq_ready;
  hav_pkg::uq30_t ry, rx;
  logic           at_valid, at_ready;
  hav_pkg::ang_t  z;

  hav_sincos u_sincos (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pts.valid),
    .up_ready (pts.ready),
    .lat_a    (pts.lat_a),
    .lon_a    (pts.lon_a),
    .lat_b    (pts.lat_b),
    .lon_b    (pts.lon_b),
    .dn_valid (sc_valid),
    .dn_ready (sc_ready),
    .sc       (sc)
  );

  hav_prod u_prod (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sc_valid),
    .up_ready (sc_ready),
    .sc       (sc),
    .dn_valid (pr_valid),
    .dn_ready (pr_ready),
    .aux      (aux)
  );

  hav_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .up_valid (pr_valid),
    .up_ready (pr_ready),
    .aux      (aux),
    .dn_valid (sq_valid),
    .dn_ready (sq_ready),
    .ry       (ry),
    .rx       (rx)
  );

  hav_atan u_atan (
    .clk      (clk),
    .rst      (rst),
    .up_valid (sq_valid),
    .up_ready (sq_ready),
    .ry       (ry),
    .rx       (rx),
    .dn_valid (at_valid),
    .dn_ready (at_ready),
    .z        (z)
  );

  // radius scale: p = R * z, then (125 * p + 2^25) >> 26
  logic [1:0]                 sv;
  logic [2:0]                 sen;
  hav_pkg::uq30_t             zc;
  logic [54:0]                p;
  logic [63:0]                q;
  logic [hav_pkg::DIST_W-1:0] distance_mm;

  assign sen[2] = result.ready;
  assign sen[1] = !sv[1] || sen[2];
  assign sen[0] = !sv[0] || sen[1];
  assign at_ready = sen[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else begin
      if (sen[0]) begin
        sv[0] <= at_valid;
      end
      if (sen[1]) begin
        sv[1] <= sv[0];
      end
    end
  end

  always_comb begin
    if (z[32]) begin
      zc = '0;
    end else if (z > hav_pkg::HALF_PI_ANG) begin
      zc = hav_pkg::HALF_PI_U;
    end else begin
      zc = 31'(z);
    end
  end

  // 125 * p = 128 * p - 2 * p - p
  assign q = (64'(p) << 7) - (64'(p) << 1) - 64'(p) + 64'h0000_0000_0200_0000;

  always_ff @(posedge clk) begin
    if (sen[0]) begin
      p <= 55'(sphere_radius_m) * 55'(zc);
    end
    if (sen[1]) begin
      distance_mm <= q[61:26];
    end
  end

  assign result.valid       = sv[1];
  assign result.distance_mm = distance_mm;

  `HAV_ASSERT_NOW(a_stall_only_when_full, !pts.ready, result.valid && !result.ready, "input stalled while the output side can move")
  `HAV_ASSERT_NEXT(a_scale_holds, sv[0] && !sen[1], $stable(p), "scale product changed during a stall")

endmodule

// ===== rtl/hav_sincos.sv =====
// ----------------------------------------------------------------------------
// hav_sincos
// angle reduction, radian conversion and four rotation cordic lanes
// ----------------------------------------------------------------------------
module hav_sincos (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              up_valid,
  output logic                              up_ready,
  input  logic signed [hav_pkg::LAT_W-1:0]  lat_a,
  input  logic signed [hav_pkg::LON_W-1:0]  lon_a,
  input  logic signed [hav_pkg::LAT_W-1:0]  lat_b,
  input  logic signed [hav_pkg::LON_W-1:0]  lon_b,
  output logic                              dn_valid,
  input  logic                              dn_ready,
  output hav_pkg::sc_t                      sc
);

  localparam int NF = 5;
  localparam int CN = hav_pkg::CORDIC_N;
  localparam int NS = NF + CN;

  localparam logic signed [30:0] HT720 = 31'(hav_pkg::HALF_TURN_720);
  localparam logic signed [30:0] HT360 = 31'(hav_pkg::HALF_TURN_360);
  localparam logic signed [30:0] HT180 = 31'(hav_pkg::HALF_TURN_180);

  logic [NS-1:0] v;
  logic [NS:0]   en;
  logic [NS-1:0] vin;

  assign vin = {v[NS-2:0], up_valid};

  always_comb begin
    en[NS] = dn_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= vin[i];
        end
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v[NS-1];

  // lane 0: dlat, lane 1: dlon, lane 2: 2*lat_a, lane 3: 2*lat_b (half microdegrees)
  logic signed [29:0] ah [4];
  logic signed [30:0] ba [4];
  logic signed [30:0] fa [4];
  logic [3:0]         fn;
  logic [27:0]        cmag [4];
  logic [3:0]         csgn;
  logic [3:0]         cneg;
  logic [45:0]        dlo [4];
  logic [45:0]        dhi [4];
  logic [3:0]         dsgn;
  logic [3:0]         dneg;
  logic [63:0]        esum [4];
  hav_pkg::ang_t      ez [4];

  hav_pkg::cw_t       xs [CN+1][4];
  hav_pkg::cw_t       ys [CN+1][4];
  hav_pkg::ang_t      zs [CN+1][4];
  logic [3:0]         ns [CN+1];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      ah[0] <= 30'(lat_b) - 30'(lat_a);
      ah[1] <= 30'(lon_b) - 30'(lon_a);
      ah[2] <= 30'(lat_a) <<< 1;
      ah[3] <= 30'(lat_b) <<< 1;
    end
  end

  // wrap into one turn around zero
  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int l = 0; l < 4; l++) begin
        if (31'(ah[l]) < -HT360) begin
          ba[l] <= 31'(ah[l]) + HT720;
        end else if (31'(ah[l]) >= HT360) begin
          ba[l] <= 31'(ah[l]) - HT720;
        end else begin
          ba[l] <= 31'(ah[l]);
        end
      end
    end
  end

  // fold into [-90, 90] degrees, cosine flips sign
  always_comb begin
    for (int l = 0; l < 4; l++) begin
      if (ba[l] > HT180) begin
        fa[l] = HT360 - ba[l];
        fn[l] = 1'b1;
      end else if (ba[l] < -HT180) begin
        fa[l] = -HT360 - ba[l];
        fn[l] = 1'b1;
      end else begin
        fa[l] = ba[l];
        fn[l] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int l = 0; l < 4; l++) begin
        cmag[l] <= fa[l][30] ? 28'(-fa[l]) : 28'(fa[l]);
        csgn[l] <= fa[l][30];
      end
      cneg <= fn;
    end
  end

  // radian scale split into two 18-bit partial products
  always_ff @(posedge clk) begin
    if (en[3]) begin
      for (int l = 0; l < 4; l++) begin
        dlo[l] <= 46'(cmag[l]) * 46'(hav_pkg::RAD_K_LO);
        dhi[l] <= 46'(cmag[l]) * 46'(hav_pkg::RAD_K_HI);
      end
      dsgn <= csgn;
      dneg <= cneg;
    end
  end

  always_comb begin
    for (int l = 0; l < 4; l++) begin
      esum[l] = {dhi[l], 18'b0} + 64'(dlo[l]) + 64'h0000_0000_8000_0000;
      ez[l]   = dsgn[l] ? -$signed({2'b00, esum[l][62:32]}) : $signed({2'b00, esum[l][62:32]});
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      for (int l = 0; l < 4; l++) begin
        xs[0][l] <= hav_pkg::CORDIC_GAIN;
        ys[0][l] <= '0;
        zs[0][l] <= ez[l];
      end
      ns[0] <= dneg;
    end
    for (int s = 0; s < CN; s++) begin
      if (en[NF+s]) begin
        for (int l = 0; l < 4; l++) begin
          if (!zs[s][l][32]) begin
            xs[s+1][l] <= xs[s][l] - (ys[s][l] >>> s);
            ys[s+1][l] <= ys[s][l] + (xs[s][l] >>> s);
            zs[s+1][l] <= zs[s][l] - $signed({1'b0, hav_pkg::atan_q30(5'(s))});
          end else begin
            xs[s+1][l] <= xs[s][l] + (ys[s][l] >>> s);
            ys[s+1][l] <= ys[s][l] - (xs[s][l] >>> s);
            zs[s+1][l] <= zs[s][l] + $signed({1'b0, hav_pkg::atan_q30(5'(s))});
          end
        end
        ns[s+1] <= ns[s];
      end
    end
  end

  assign sc.s1 = 32'(ys[CN][0]);
  assign sc.s2 = 32'(ys[CN][1]);
  assign sc.c1 = 32'(xs[CN][2]);
  assign sc.c2 = 32'(xs[CN][3]);
  assign sc.n1 = ns[CN][2];
  assign sc.n2 = ns[CN][3];

endmodule

// ===== rtl/hav_prod.sv =====
// ----------------------------------------------------------------------------
// hav_prod
// haversine term a = s1^2 + c1*c2*s2^2, clamped to [0, 1]
// ----------------------------------------------------------------------------
module hav_prod (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  hav_pkg::sc_t   sc,
  output logic           dn_valid,
  input  logic           dn_ready,
  output hav_pkg::uq30_t aux
);

  localparam int NS = 4;
  localparam logic signed [33:0] ONE_W = 34'sd1073741824;

  logic [NS-1:0] v;
  logic [NS:0]   en;
  logic [NS-1:0] vin;

  assign vin = {v[NS-2:0], up_valid};

  always_comb begin
    en[NS] = dn_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= vin[i];
        end
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v[NS-1];

  hav_pkg::q30_t      s1, s2, c1, c2;
  hav_pkg::q30_t      ss1, ss2, cc;
  hav_pkg::q30_t      ss1_d, t;
  logic signed [33:0] sm;

  // folded cosines are negated before the product so rounding sees the signed value
  always_ff @(posedge clk) begin
    if (en[0]) begin
      s1 <= sc.s1;
      s2 <= sc.s2;
      c1 <= sc.n1 ? -sc.c1 : sc.c1;
      c2 <= sc.n2 ? -sc.c2 : sc.c2;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      ss1 <= hav_pkg::mulq(s1, s1);
      ss2 <= hav_pkg::mulq(s2, s2);
      cc  <= hav_pkg::mulq(c1, c2);
    end
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      ss1_d <= ss1;
      t     <= hav_pkg::mulq(cc, ss2);
    end
  end

  assign sm = 34'(ss1_d) + 34'(t);

  always_ff @(posedge clk) begin
    if (en[3]) begin
      if (sm[33]) begin
        aux <= '0;
      end else if (sm > ONE_W) begin
        aux <= hav_pkg::Q30_ONE;
      end else begin
        aux <= 31'(sm);
      end
    end
  end

endmodule

// ===== rtl/hav_sqrt.sv =====
// ----------------------------------------------------------------------------
// hav_sqrt
// two restoring square roots, sqrt(a) and sqrt(1 - a), one bit per stage
// ----------------------------------------------------------------------------
module hav_sqrt (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  hav_pkg::uq30_t aux,
  output logic           dn_valid,
  input  logic           dn_ready,
  output hav_pkg::uq30_t ry,
  output hav_pkg::uq30_t rx
);

  localparam int NB = 31;
  localparam int NS = NB + 1;

  logic [NS-1:0] v;
  logic [NS:0]   en;
  logic [NS-1:0] vin;

  assign vin = {v[NS-2:0], up_valid};

  always_comb begin
    en[NS] = dn_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= vin[i];
        end
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v[NS-1];

  // lane 0 works on a, lane 1 on 1 - a; both radicands carry 30 extra fraction bits
  logic [60:0] rem [NS][2];
  logic [61:0] res [NS][2];

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0][0] <= {aux, 30'b0};
      rem[0][1] <= {31'(hav_pkg::Q30_ONE - aux), 30'b0};
      res[0][0] <= '0;
      res[0][1] <= '0;
    end
    for (int s = 1; s < NS; s++) begin
      if (en[s]) begin
        for (int l = 0; l < 2; l++) begin
          if ({1'b0, rem[s-1][l]} >= res[s-1][l] + (62'(1) << (2 * (NS - 1 - s)))) begin
            rem[s][l] <= rem[s-1][l] - 61'(res[s-1][l] + (62'(1) << (2 * (NS - 1 - s))));
            res[s][l] <= (res[s-1][l] >> 1) + (62'(1) << (2 * (NS - 1 - s)));
          end else begin
            rem[s][l] <= rem[s-1][l];
            res[s][l] <= res[s-1][l] >> 1;
          end
        end
      end
    end
  end

  assign ry = 31'(res[NS-1][0]);
  assign rx = 31'(res[NS-1][1]);

endmodule

// ===== rtl/hav_atan.sv =====
// ----------------------------------------------------------------------------
// hav_atan
// vectoring cordic for atan2(y, x), one iteration per stage
// ----------------------------------------------------------------------------
module hav_atan (
  input  logic           clk,
  input  logic           rst,
  input  logic           up_valid,
  output logic           up_ready,
  input  hav_pkg::uq30_t ry,
  input  hav_pkg::uq30_t rx,
  output logic           dn_valid,
  input  logic           dn_ready,
  output hav_pkg::ang_t  z
);

  localparam int NS = hav_pkg::CORDIC_N;

  logic [NS-1:0] v;
  logic [NS:0]   en;
  logic [NS-1:0] vin;

  assign vin = {v[NS-2:0], up_valid};

  always_comb begin
    en[NS] = dn_ready;
    for (int i = NS - 1; i >= 0; i--) begin
      en[i] = !v[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int i = 0; i < NS; i++) begin
        if (en[i]) begin
          v[i] <= vin[i];
        end
      end
    end
  end

  assign up_ready = en[0];
  assign dn_valid = v[NS-1];

  hav_pkg::cw_t  xi [NS];
  hav_pkg::cw_t  yi [NS];
  hav_pkg::ang_t zi [NS];
  hav_pkg::cw_t  xo [NS];
  hav_pkg::cw_t  yo [NS];
  hav_pkg::ang_t zo [NS];

  always_comb begin
    xi[0] = $signed({3'b000, rx});
    yi[0] = $signed({3'b000, ry});
    zi[0] = '0;
    for (int s = 1; s < NS; s++) begin
      xi[s] = xo[s-1];
      yi[s] = yo[s-1];
      zi[s] = zo[s-1];
    end
  end

  // rotate towards y = 0 and collect the angle
  always_ff @(posedge clk) begin
    for (int s = 0; s < NS; s++) begin
      if (en[s]) begin
        if (!yi[s][33]) begin
          xo[s] <= xi[s] + (yi[s] >>> s);
          yo[s] <= yi[s] - (xi[s] >>> s);
          zo[s] <= zi[s] + $signed({1'b0, hav_pkg::atan_q30(5'(s))});
        end else begin
          xo[s] <= xi[s] - (yi[s] >>> s);
          yo[s] <= yi[s] + (xi[s] >>> s);
          zo[s] <= zi[s] - $signed({1'b0, hav_pkg::atan_q30(5'(s))});
        end
      end
    end
  end

  assign z = zo[NS-1];

endmodule

// ===== tb/hav_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// haversine distance checker
// watches the point, distance and radius channels, predicts each distance
// in fixed point and compares it with the block's output in order
// ----------------------------------------------------------------------------
module hav_checker (
  input  logic clk,
  input  logic rst,
  hav_pts_if   pts,
  hav_dist_if  result,
  hav_cfg_if   cfg,
  output int   failures,
  output int   pending
);

  localparam longint TURN_HALF_UDEG = 720000000;
  localparam longint HALF_TURN_HU   = 360000000;
  localparam longint QUARTER_HU     = 180000000;
  localparam longint Q30_UNIT       = 64'sd1 << 30;
  localparam longint PI_HALF_Q30    = 1686629713;

  logic [hav_pkg::RADIUS_W-1:0] radius_m;
  logic [hav_pkg::DIST_W-1:0]   expected_dist[$];

  function automatic longint arctan_step(input int i);
    longint t [32] = '{843314856, 497837829, 263043836, 133525158, 67021686,
      33543515, 16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
      131071, 65535, 32767, 16383, 8191, 4095, 2047, 1024, 511, 255, 127, 63,
      31, 15, 8, 4, 2, 1, 0};
    return t[i];
  endfunction

  function automatic longint q30_mul(input longint a, input longint b);
    return (a * b + (64'sd1 <<< 29)) >>> 30;
  endfunction

  // angle in half-microdegrees, folded into [-90,90] deg before rotation
  function automatic void half_angle_sin_cos(input longint h, output longint s,
                                             output longint c);
    longint a, x, y, z, nx;
    longint unsigned mag;
    bit neg;
    a = h % TURN_HALF_UDEG;
    neg = 0;
    if (a < 0) a += TURN_HALF_UDEG;
    if (a >= HALF_TURN_HU) a -= TURN_HALF_UDEG;
    if (a > QUARTER_HU) begin
      a = HALF_TURN_HU - a;
      neg = 1;
    end else if (a < -QUARTER_HU) begin
      a = -HALF_TURN_HU - a;
      neg = 1;
    end
    mag = longint'(a < 0 ? -a : a) * 64'd40244552545;
    z = longint'((mag + (64'd1 << 31)) >> 32);
    if (a < 0) z = -z;
    x = 652032874;
    y = 0;
    for (int i = 0; i < hav_pkg::CORDIC_N; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_step(i);
      end else begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_step(i);
      end
      x = nx;
    end
    s = y;
    c = neg ? -x : x;
  endfunction

  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic [hav_pkg::DIST_W-1:0] predict_distance(
      input logic signed [hav_pkg::LAT_W-1:0] la,
      input logic signed [hav_pkg::LON_W-1:0] oa,
      input logic signed [hav_pkg::LAT_W-1:0] lb,
      input logic signed [hav_pkg::LON_W-1:0] ob,
      input logic [hav_pkg::RADIUS_W-1:0] r);
    longint s1, s2, c1, c2, unused, hav, x, y, z, nx;
    longint unsigned d;
    half_angle_sin_cos(longint'(lb) - longint'(la), s1, unused);
    half_angle_sin_cos(longint'(ob) - longint'(oa), s2, unused);
    half_angle_sin_cos(2 * longint'(la), unused, c1);
    half_angle_sin_cos(2 * longint'(lb), unused, c2);
    hav = q30_mul(s1, s1) + q30_mul(q30_mul(c1, c2), q30_mul(s2, s2));
    if (hav < 0) hav = 0;
    if (hav > Q30_UNIT) hav = Q30_UNIT;
    y = longint'(root_floor(longint'(hav) << 30));
    x = longint'(root_floor(longint'(Q30_UNIT - hav) << 30));
    z = 0;
    for (int i = 0; i < hav_pkg::CORDIC_N; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y = y - (x >>> i);
        z += arctan_step(i);
      end else begin
        nx = x - (y >>> i);
        y = y + (x >>> i);
        z -= arctan_step(i);
      end
      x = nx;
    end
    if (z < 0) z = 0;
    if (z > PI_HALF_Q30) z = PI_HALF_Q30;
    d = (longint'(r) * longint'(z) * 125 + (64'd1 << 25)) >> 26;
    return d[hav_pkg::DIST_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      radius_m <= hav_pkg::RADIUS_RESET;
      expected_dist.delete();
      failures <= 0;
      pending <= 0;
    end else begin
      if (cfg.valid && cfg.ready) radius_m <= cfg.data;
      if (pts.valid && pts.ready)
        expected_dist = {expected_dist, predict_distance(pts.lat_a, pts.lon_a,
                                                         pts.lat_b, pts.lon_b,
                                                         radius_m)};
      if (result.valid && result.ready) begin
        if (expected_dist.size() == 0) begin
          $error("distance_mm: unexpected transaction, actual %0d", result.distance_mm);
          failures <= failures + 1;
        end else begin
          if (result.distance_mm !== expected_dist[0]) begin
            $error("distance_mm: expected %0d actual %0d", expected_dist[0],
                   result.distance_mm);
            failures <= failures + 1;
          end
          void'(expected_dist.pop_front());
        end
      end
      pending <= expected_dist.size();
    end
  end
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// haversine distance testbench
// drives point pairs in random bursts over several radius settings while the
// distance receiver stalls; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module testbench;

  logic clk;
  logic rst;
  int   failures;
  int   pending;
  int   burst_left;
  bit   long_hold_done;

  hav_pts_if  pts();
  hav_dist_if result();
  hav_cfg_if  cfg();

  haversine_distance dut (.clk(clk), .rst(rst), .pts(pts), .result(result), .cfg(cfg));
  hav_checker chk (.clk(clk), .rst(rst), .pts(pts), .result(result), .cfg(cfg),
                   .failures(failures), .pending(pending));

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_pair(input int la, input int oa, input int lb, input int ob);
    pts.valid <= 1'b1;
    pts.lat_a <= la[hav_pkg::LAT_W-1:0];
    pts.lon_a <= oa[hav_pkg::LON_W-1:0];
    pts.lat_b <= lb[hav_pkg::LAT_W-1:0];
    pts.lon_b <= ob[hav_pkg::LON_W-1:0];
    do @(posedge clk); while (!pts.ready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 3) != 0) begin
        pts.valid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  task automatic set_radius(input logic [hav_pkg::RADIUS_W-1:0] r);
    pts.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.data  <= r;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  function automatic int rand_lat();
    return int'($urandom_range(0, 180000000)) - 90000000;
  endfunction

  function automatic int rand_lon();
    return int'($urandom_range(0, 360000000)) - 180000000;
  endfunction

  task automatic random_pairs(input int n);
    int la, oa;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 9))
        0: send_pair($urandom(), $urandom(), $urandom(), $urandom());
        1: begin
          // near-antipodal pair
          la = rand_lat();
          oa = rand_lon();
          send_pair(la, oa, -la + int'($urandom_range(0, 2000)) - 1000,
                    oa + 180000000 - int'($urandom_range(0, 2000)));
        end
        2: begin
          la = rand_lat();
          oa = rand_lon();
          send_pair(la, oa, la + int'($urandom_range(0, 20)) - 10,
                    oa + int'($urandom_range(0, 20)) - 10);
        end
        default: send_pair(rand_lat(), rand_lon(), rand_lat(), rand_lon());
      endcase
    end
  endtask

  // receiver stalls, with one long hold-off so the pipeline backs up
  initial begin
    int run;
    result.ready <= 1'b0;
    long_hold_done = 0;
    @(negedge rst);
    forever begin
      if (!long_hold_done && pending > 20) begin
        long_hold_done = 1;
        result.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
      run = $urandom_range(1, 40);
      case ($urandom_range(0, 3))
        0: begin
          result.ready <= 1'b1;
          repeat (run) @(posedge clk);
        end
        1: begin
          result.ready <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        default: begin
          repeat (run) begin
            result.ready <= 1'($urandom_range(0, 1));
            @(posedge clk);
          end
        end
      endcase
    end
  end

  initial begin
    rst = 1'b1;
    pts.valid <= 1'b0;
    pts.lat_a <= '0;
    pts.lon_a <= '0;
    pts.lat_b <= '0;
    pts.lon_b <= '0;
    cfg.valid <= 1'b0;
    cfg.data  <= '0;
    burst_left = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, poles, antipodes, wraps and raw bit patterns
    send_pair(0, 0, 0, 0);
    send_pair(90000000, 0, -90000000, 0);
    send_pair(0, -180000000, 0, 180000000);
    send_pair(0, 0, 0, 180000000);
    send_pair(45000000, 10000000, -45000000, -170000000);
    send_pair(-90000000, -180000000, 90000000, 180000000);
    send_pair(90000000, 123456789, 90000000, -98765432);
    send_pair(38736946, -9142685, 41157944, -8629105);
    send_pair(0, 0, 1, 1);
    send_pair(28'h7ffffff, 29'h0fffffff, 28'h8000000, 29'h10000000);
    send_pair(28'h8000000, 29'h10000000, 28'h7ffffff, 29'h0fffffff);
    send_pair('1, '1, '0, '0);
    send_pair(100000000, 0, 100000000, 90000000);
    send_pair(-135000000, 200000000, 60000000, -250000000);
    send_pair(0, 90000000, 0, -90000000);
    send_pair(12345678, 0, -12345678, 179999999);
    random_pairs(390);

    set_radius(24'd16777215);
    random_pairs(200);
    set_radius(24'd1);
    random_pairs(200);
    set_radius(24'd0);
    random_pairs(60);
    set_radius(24'($urandom_range(1, 16777215)));
    random_pairs(220);
    set_radius(24'd1737400);
    random_pairs(220);

    pts.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (failures == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule

// ===== sim.f =====
+incdir+rtl
rtl/hav_pkg.sv
rtl/hav_if.sv
rtl/hav_sincos.sv
rtl/hav_prod.sv
rtl/hav_sqrt.sv
rtl/hav_atan.sv
rtl/haversine_distance.sv
tb/hav_checker.sv
tb/testbench.sv
